// ----- hw/rtl/ests_pkg.sv -----
// ============================================================================
// ests_pkg
// Shared types, constants and arithmetic helpers for the ETC1 selector
// table search.
// ============================================================================
package ests_pkg;

    localparam int BLOCK_PIXELS = 16;
    localparam int TABLE_COUNT  = 8;

    localparam int COUNT_W = (BLOCK_PIXELS > 1) ? $clog2(BLOCK_PIXELS) : 1;
    localparam int TBL_W   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam int PIX_ERR_W = 18;
    localparam int SUM_W     = 22;
    localparam int SEL_W     = 32;
    localparam int BEST_W    = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [0:0] MODE_5BIT = 1'b0;
    localparam logic [0:0] MODE_4BIT = 1'b1;

    // Standard ETC1 intensity modifiers, one row per table
    localparam logic signed [8:0] INTEN_MODS [8][4] = '{
        '{-9'sd8,   -9'sd2,  9'sd2,  9'sd8},
        '{-9'sd17,  -9'sd5,  9'sd5,  9'sd17},
        '{-9'sd29,  -9'sd9,  9'sd9,  9'sd29},
        '{-9'sd42,  -9'sd13, 9'sd13, 9'sd42},
        '{-9'sd60,  -9'sd18, 9'sd18, 9'sd60},
        '{-9'sd80,  -9'sd24, 9'sd24, 9'sd80},
        '{-9'sd106, -9'sd33, 9'sd33, 9'sd106},
        '{-9'sd183, -9'sd47, 9'sd47, 9'sd183}
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } base_t;

    typedef struct packed {
        logic               valid;
        logic               block_end;
        logic [COUNT_W-1:0] pos;
    } stage_ctrl_t;

    function automatic logic [7:0] expand_channel(input logic [4:0] c,
                                                  input logic [0:0] mode);
        logic [7:0] r;
        if (mode == MODE_4BIT)
        begin
            r = {c[3:0], c[3:0]};
        end
        else
        begin
            r = {c, c[4:2]};
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp255(input logic signed [9:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 10'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[15:0];
    endfunction

    // Squared RGB distance from pixel to one clamped palette color
    function automatic logic [PIX_ERR_W-1:0] palette_err(input pixel_t pix,
                                                         input pixel_t base,
                                                         input logic signed [8:0] m);
        logic [7:0] pr;
        logic [7:0] pg;
        logic [7:0] pb;
        pr = clamp255($signed({2'b00, base.red})   + 10'(m));
        pg = clamp255($signed({2'b00, base.green}) + 10'(m));
        pb = clamp255($signed({2'b00, base.blue})  + 10'(m));
        return PIX_ERR_W'(sq_diff(pix.red, pr)) + PIX_ERR_W'(sq_diff(pix.green, pg))
             + PIX_ERR_W'(sq_diff(pix.blue, pb));
    endfunction

endpackage

// ----- hw/rtl/etc1_selector_table_search.sv -----
// Path: the result word reaches m_tvalid through the input register, palette
//   fit, accumulate and output stages after the block's last pixel is accepted.
// Throughput: one pixel per cycle; the four stages advance together and hold
//   only while a result word waits in the output register.
// Reset: rst_n clears color_mode, the pixel count, the running error sums and selectors.
// ============================================================================
// etc1_selector_table_search
// ETC1 intensity table search over one block of streamed pixels.
// ============================================================================
module etc1_selector_table_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,   // color_mode
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue,
    // [28:24] base_red, [33:29] base_green, [38:34] base_blue
    input  logic [ests_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,     // last_pixel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [21:0] fit_error, [24:22] best_table, [56:25] selector_codes
    output logic [ests_pkg::M_TDATA_W-1:0] m_tdata
);
    import ests_pkg::*;

    logic [0:0]           color_mode_reg;
    logic                 advance;
    stage_ctrl_t          in_ctrl;
    stage_ctrl_t          fit_ctrl;
    pixel_t               in_pix;
    base_t                in_base;
    logic [PIX_ERR_W-1:0] fit_err [TABLE_COUNT];
    logic [1:0]           fit_sel [TABLE_COUNT];
    logic                 snap_valid;
    logic [SUM_W-1:0]     snap_sum [TABLE_COUNT];
    logic [SEL_W-1:0]     snap_sel [TABLE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= MODE_5BIT;
        end
        else if (cfg_we)
        begin
            color_mode_reg <= cfg_wdata;
        end
    end

    // advance the whole pipe unless a result word is stuck
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    ests_input u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .ctrl     (in_ctrl),
        .pix      (in_pix),
        .base     (in_base)
    );

    ests_fit u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .color_mode (color_mode_reg),
        .ctrl_in    (in_ctrl),
        .pix        (in_pix),
        .base       (in_base),
        .ctrl_out   (fit_ctrl),
        .err        (fit_err),
        .sel        (fit_sel)
    );

    ests_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .ctrl       (fit_ctrl),
        .err        (fit_err),
        .sel        (fit_sel),
        .snap_valid (snap_valid),
        .snap_sum   (snap_sum),
        .snap_sel   (snap_sel)
    );

    ests_pick u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .snap_valid (snap_valid),
        .snap_sum   (snap_sum),
        .snap_sel   (snap_sel),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- hw/rtl/ests_input.sv -----
// ============================================================================
// ests_input
// Input register: unpacks the slave word, counts pixels within a block and
// latches the base color on the first pixel.
// ============================================================================
module ests_input (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            s_tvalid,
    input  logic [ests_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output ests_pkg::stage_ctrl_t           ctrl,
    output ests_pkg::pixel_t                pix,
    output ests_pkg::base_t                 base
);
    import ests_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    base_t              latched_reg;
    base_t              base_sel;
    base_t              base_in;
    stage_ctrl_t        ctrl_reg;
    pixel_t             pix_reg;
    base_t              base_reg;
    logic               accept;
    logic               first;
    logic               blk_end;

    assign accept  = s_tvalid && advance;
    assign first   = (count_reg == '0);
    assign blk_end = s_tlast || (count_reg == COUNT_W'(BLOCK_PIXELS - 1));

    assign base_in.red   = s_tdata[28:24];
    assign base_in.green = s_tdata[33:29];
    assign base_in.blue  = s_tdata[38:34];

    assign base_sel   = first ? base_in : latched_reg;
    assign count_next = blk_end ? '0 : count_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            latched_reg <= '0;
            ctrl_reg    <= '0;
        end
        else if (advance)
        begin
            ctrl_reg.valid     <= s_tvalid;
            ctrl_reg.block_end <= blk_end;
            ctrl_reg.pos       <= count_reg;
            if (s_tvalid)
            begin
                count_reg   <= count_next;
                latched_reg <= base_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg.red   <= s_tdata[7:0];
            pix_reg.green <= s_tdata[15:8];
            pix_reg.blue  <= s_tdata[23:16];
            base_reg      <= base_sel;
        end
    end

    assign ctrl = ctrl_reg;
    assign pix  = pix_reg;
    assign base = base_reg;

endmodule

// ----- hw/rtl/ests_fit.sv -----
// ============================================================================
// ests_fit
// Per-table palette fit: expands the base color, forms the four clamped
// palette colors of each table and registers the nearest one and its error.
// ============================================================================
module ests_fit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [0:0]                       color_mode,
    input  ests_pkg::stage_ctrl_t            ctrl_in,
    input  ests_pkg::pixel_t                 pix,
    input  ests_pkg::base_t                  base,
    output ests_pkg::stage_ctrl_t            ctrl_out,
    output logic [ests_pkg::PIX_ERR_W-1:0]   err [ests_pkg::TABLE_COUNT],
    output logic [1:0]                       sel [ests_pkg::TABLE_COUNT]
);
    import ests_pkg::*;

    pixel_t             base_exp;
    stage_ctrl_t        ctrl_reg;
    logic [PIX_ERR_W-1:0] err_next [TABLE_COUNT];
    logic [1:0]           sel_next [TABLE_COUNT];
    logic [PIX_ERR_W-1:0] err_reg  [TABLE_COUNT];
    logic [1:0]           sel_reg  [TABLE_COUNT];

    assign base_exp.red   = expand_channel(base.red,   color_mode);
    assign base_exp.green = expand_channel(base.green, color_mode);
    assign base_exp.blue  = expand_channel(base.blue,  color_mode);

    // Nearest palette entry per table, lowest selector wins ties
    always_comb
    begin : fit_tables
        logic [PIX_ERR_W-1:0] e;
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            err_next[t] = palette_err(pix, base_exp, INTEN_MODS[t][0]);
            sel_next[t] = 2'd0;
            for (int s = 1; s < 4; s++)
            begin
                e = palette_err(pix, base_exp, INTEN_MODS[t][s]);
                if (e < err_next[t])
                begin
                    err_next[t] = e;
                    sel_next[t] = 2'(s);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            err_reg <= err_next;
            sel_reg <= sel_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign err      = err_reg;
    assign sel      = sel_reg;

endmodule

// ----- hw/rtl/ests_accum.sv -----
// ============================================================================
// ests_accum
// Per-table error sums and packed selectors; at the end of a block the final
// totals move to a snapshot and the running state clears.
// ============================================================================
module ests_accum (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  ests_pkg::stage_ctrl_t            ctrl,
    input  logic [ests_pkg::PIX_ERR_W-1:0]   err [ests_pkg::TABLE_COUNT],
    input  logic [1:0]                       sel [ests_pkg::TABLE_COUNT],
    output logic                             snap_valid,
    output logic [ests_pkg::SUM_W-1:0]       snap_sum [ests_pkg::TABLE_COUNT],
    output logic [ests_pkg::SEL_W-1:0]       snap_sel [ests_pkg::TABLE_COUNT]
);
    import ests_pkg::*;

    logic [SUM_W-1:0] sum_reg      [TABLE_COUNT];
    logic [SEL_W-1:0] sel_reg      [TABLE_COUNT];
    logic [SUM_W-1:0] sum_next     [TABLE_COUNT];
    logic [SEL_W-1:0] sel_next     [TABLE_COUNT];
    logic [SUM_W-1:0] snap_sum_reg [TABLE_COUNT];
    logic [SEL_W-1:0] snap_sel_reg [TABLE_COUNT];
    logic             snap_valid_reg;

    always_comb
    begin : add_pixel
        logic [SUM_W:0] s;
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            s = {1'b0, sum_reg[t]} + (SUM_W + 1)'(err[t]);
            sum_next[t] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
            sel_next[t] = sel_reg[t] | (SEL_W'(sel[t]) << {ctrl.pos, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            for (int t = 0; t < TABLE_COUNT; t++)
            begin
                sum_reg[t] <= '0;
                sel_reg[t] <= '0;
            end
        end
        else if (advance)
        begin
            snap_valid_reg <= ctrl.valid && ctrl.block_end;
            if (ctrl.valid)
            begin
                for (int t = 0; t < TABLE_COUNT; t++)
                begin
                    // clear on block end so the next pixel starts fresh
                    sum_reg[t] <= ctrl.block_end ? '0 : sum_next[t];
                    sel_reg[t] <= ctrl.block_end ? '0 : sel_next[t];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl.valid && ctrl.block_end)
        begin
            snap_sum_reg <= sum_next;
            snap_sel_reg <= sel_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_sum   = snap_sum_reg;
    assign snap_sel   = snap_sel_reg;

endmodule

// ----- hw/rtl/ests_pick.sv -----
// ============================================================================
// ests_pick
// Picks the table with the lowest total error and holds the result word in
// the master-side output register.
// ============================================================================
module ests_pick (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             snap_valid,
    input  logic [ests_pkg::SUM_W-1:0]       snap_sum [ests_pkg::TABLE_COUNT],
    input  logic [ests_pkg::SEL_W-1:0]       snap_sel [ests_pkg::TABLE_COUNT],
    output logic                             m_tvalid,
    output logic [ests_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ests_pkg::*;

    logic [SUM_W-1:0]     best_err;
    logic [TBL_W-1:0]     best_idx;
    logic [SEL_W-1:0]     best_sel;
    logic                 valid_reg;
    logic [M_TDATA_W-1:0] data_reg;

    // Strict compare keeps the lowest index on ties
    always_comb
    begin
        best_err = snap_sum[0];
        best_sel = snap_sel[0];
        best_idx = '0;
        for (int t = 1; t < TABLE_COUNT; t++)
        begin
            if (snap_sum[t] < best_err)
            begin
                best_err = snap_sum[t];
                best_sel = snap_sel[t];
                best_idx = TBL_W'(t);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && snap_valid)
        begin
            data_reg <= M_TDATA_W'({best_sel, BEST_W'(best_idx), best_err});
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- hw/rtl/ests_checker.sv -----
// ============================================================================
// ests_checker
// Port-level checks for the ETC1 selector table search.
// ============================================================================
module ests_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ests_pkg::M_TDATA_W-1:0] m_tdata
);
    import ests_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // with no result pending the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a marked last pixel yields a result when the output side does not stall
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("missing result after last pixel");

    a_table_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[24:22] < BEST_W'(TABLE_COUNT)) || (TABLE_COUNT == 8))
        else $error("best table out of range");

    a_error_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:0] <= 22'(BLOCK_PIXELS * 3 * 255 * 255))
        else $error("block error above bound");

endmodule

bind etc1_selector_table_search ests_checker u_ests_checker (.*);
